// ===== rtl/tbp_pkg.sv =====
// Shared types, constants and small helper functions for the tournament branch predictor.
// Used by tbp_ras, tbp_tables and the top level; depends on nothing else.
package tbp_pkg;

   // Item kinds.
   localparam logic KIND_PREDICT = 1'b0;
   localparam logic KIND_UPDATE  = 1'b1;

   // Branch classes carried by an update item.
   localparam logic [1:0] CLASS_OTHER  = 2'd0;
   localparam logic [1:0] CLASS_BRANCH = 2'd1;
   localparam logic [1:0] CLASS_JAL    = 2'd2;
   localparam logic [1:0] CLASS_JALR   = 2'd3;

   // Instruction decode constants.
   localparam logic [6:0]  OP_JAL     = 7'h6f;
   localparam logic [31:0] JALR_MASK  = 32'h0000_707f;
   localparam logic [31:0] JALR_MATCH = 32'h0000_0067;
   localparam logic [4:0]  REG_ZERO   = 5'd0;
   localparam logic [4:0]  LINK_RA    = 5'd1;
   localparam logic [4:0]  LINK_ALT   = 5'd5;

   // The BTB tag is the pc shifted right by this many bits.
   localparam int TAG_SHIFT = 11;
   localparam int TAG_W     = 32 - TAG_SHIFT;

   typedef struct packed {
      logic             valid;
      logic [TAG_W-1:0] tag;
      logic [31:0]      target;
   } btb_entry_type;

   // Control that goes with an item into the table pipeline.
   typedef struct packed {
      logic valid;
      logic train;
      logic actual;
   } lookup_type;

   // Table contents seen by the item in the last stage, forwarding applied.
   typedef struct packed {
      logic [1:0]    lc;
      btb_entry_type btb;
      logic [1:0]    gc;
      logic [1:0]    ch;
   } table_read_type;

   // Writes issued by the item in the last stage.
   typedef struct packed {
      logic          lc_we;
      logic [1:0]    lc;
      logic          gc_we;
      logic [1:0]    gc;
      logic          ch_we;
      logic [1:0]    ch;
      logic          btb_we;
      btb_entry_type btb;
   } table_write_type;

   typedef struct packed {
      logic        pop;
      logic [31:0] target;
   } ras_type;

   // Per-item payload carried down the pipeline.
   typedef struct packed {
      logic             predict;
      logic             train;
      logic             actual;
      logic             mispredict;
      logic [TAG_W-1:0] tag;
      logic [31:0]      new_target;
      logic             ret_pop;
      logic [31:0]      ret_target;
   } item_type;

   function automatic logic is_call(input logic [31:0] raw);
      logic [4:0] rd;
      logic [4:0] rs1;
      logic       link;
      logic       result;
      rd     = raw[11:7];
      rs1    = raw[19:15];
      link   = (rd == LINK_RA) || (rd == LINK_ALT);
      result = 1'b0;
      if (raw[6:0] == OP_JAL) begin
         result = link;
      end else if ((raw & JALR_MASK) == JALR_MATCH) begin
         result = link && (rs1 != rd);
      end
      return result;
   endfunction

   function automatic logic is_return(input logic [31:0] raw);
      logic [4:0] rd;
      logic [4:0] rs1;
      rd  = raw[11:7];
      rs1 = raw[19:15];
      return ((raw & JALR_MASK) == JALR_MATCH) && (rd == REG_ZERO) &&
             ((rs1 == LINK_RA) || (rs1 == LINK_ALT));
   endfunction

   function automatic logic [1:0] ctr_move(input logic [1:0] c, input logic up);
      logic [1:0] result;
      result = c;
      if (up) begin
         if (c != 2'd3) result = c + 2'd1;
      end else begin
         if (c != 2'd0) result = c - 2'd1;
      end
      return result;
   endfunction

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == 32'hffff_ffff) ? v : v + 32'd1;
   endfunction

endpackage

// ===== rtl/tbp_mod_const.sv =====
// Three-stage remainder by a constant divisor, using a reciprocal multiply and one correction.
// Stand-alone; used by the top level to form the table indexes.
module tbp_mod_const #(
   parameter int WIDTH   = 30,
   parameter int DIVISOR = 512
) (
   input  logic                       clock,
   input  logic                       enable,
   input  logic [WIDTH-1:0]           value,
   output logic [$clog2(DIVISOR)-1:0] remainder
);

   localparam int          RW    = $clog2(DIVISOR);
   localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(DIVISOR));

   logic [WIDTH+31:0] prod;
   logic [WIDTH-1:0]  value1_ff;
   logic [WIDTH-1:0]  quot1_ff;
   logic [WIDTH-1:0]  value2_ff;
   logic [WIDTH-1:0]  qd2_ff;
   logic [WIDTH-1:0]  diff;
   logic [WIDTH-1:0]  fixed;
   logic [RW-1:0]     rem_ff;

   // The estimated quotient is exact or one short, so the difference stays below twice the divisor.
   assign prod  = (WIDTH + 32)'(value) * (WIDTH + 32)'(RECIP);
   assign diff  = value2_ff - qd2_ff;
   assign fixed = (diff >= WIDTH'(DIVISOR)) ? diff - WIDTH'(DIVISOR) : diff;

   always_ff @(posedge clock) begin
      if (enable) begin
         value1_ff <= value;
         quot1_ff  <= prod[WIDTH+31:32];
         value2_ff <= value1_ff;
         qd2_ff    <= WIDTH'(quot1_ff * WIDTH'(DIVISOR));
         rem_ff    <= fixed[RW-1:0];
      end
   end

   assign remainder = rem_ff;

endmodule

// ===== rtl/tbp_ras.sv =====
// Circular return-address stack: pops on a predicted return, pushes pc+4 on a call.
// Depends on tbp_pkg for instruction decode and the result type.
module tbp_ras #(
   parameter int DEPTH = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [31:0]       pc,
   input  logic [31:0]       raw,
   output tbp_pkg::ras_type  ret
);

   localparam int TW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [31:0]   stack_ff [DEPTH];
   logic [TW-1:0] top_ff;
   logic [TW-1:0] top_inc;
   logic [TW-1:0] top_dec;
   logic [CW-1:0] count_ff;
   logic          pop;
   logic          call;

   assign pop  = tbp_pkg::is_return(raw) && (count_ff != '0);
   assign call = tbp_pkg::is_call(raw);

   assign top_inc = (top_ff == TW'(DEPTH - 1)) ? '0 : top_ff + 1'b1;
   assign top_dec = (top_ff == '0) ? TW'(DEPTH - 1) : top_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff   <= '0;
         count_ff <= '0;
      end else if (step) begin
         if (pop) begin
            top_ff   <= top_dec;
            count_ff <= count_ff - 1'b1;
         end else if (call) begin
            top_ff <= top_inc;
            if (count_ff < CW'(DEPTH)) count_ff <= count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step && !pop && call) begin
         stack_ff[top_inc] <= pc + 32'd4;
      end
   end

   assign ret.pop    = pop;
   assign ret.target = stack_ff[top_ff];

endmodule

// ===== rtl/tbp_tables.sv =====
// Prediction tables (local history, local counters, BTB, gshare counters, chooser) with
// registered reads, one-ahead write forwarding and the clearing pass; uses tbp_pkg types.
module tbp_tables #(
   parameter int BTB_ENTRIES          = 512,
   parameter int LOCAL_TABLE_ENTRIES  = 1024,
   parameter int LOCAL_HISTORY_BITS   = 10,
   parameter int GLOBAL_TABLE_ENTRIES = 4096
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    adv,
   input  tbp_pkg::lookup_type                     a_lookup,
   input  logic [$clog2(BTB_ENTRIES)-1:0]          a_bi,
   input  logic [$clog2(LOCAL_TABLE_ENTRIES)-1:0]  a_li,
   input  logic [$clog2(GLOBAL_TABLE_ENTRIES)-1:0] a_gi,
   output tbp_pkg::table_read_type                 c_read,
   input  tbp_pkg::table_write_type                c_write,
   output logic                                    busy
);

   localparam int BI_W       = $clog2(BTB_ENTRIES);
   localparam int LI_W       = $clog2(LOCAL_TABLE_ENTRIES);
   localparam int GI_W       = $clog2(GLOBAL_TABLE_ENTRIES);
   localparam int HB         = LOCAL_HISTORY_BITS;
   localparam int LC_ENTRIES = 1 << HB;
   localparam int MAX1       = (BTB_ENTRIES > LOCAL_TABLE_ENTRIES) ?
                               BTB_ENTRIES : LOCAL_TABLE_ENTRIES;
   localparam int MAX2       = (MAX1 > LC_ENTRIES) ? MAX1 : LC_ENTRIES;
   localparam int CLR_LEN    = (MAX2 > GLOBAL_TABLE_ENTRIES) ? MAX2 : GLOBAL_TABLE_ENTRIES;
   localparam int CLR_W      = $clog2(CLR_LEN);

   logic [HB-1:0]          lh_mem  [LOCAL_TABLE_ENTRIES];
   logic [1:0]             lc_mem  [LC_ENTRIES];
   tbp_pkg::btb_entry_type btb_mem [BTB_ENTRIES];
   logic [1:0]             gc_mem  [GLOBAL_TABLE_ENTRIES];
   logic [1:0]             ch_mem  [GLOBAL_TABLE_ENTRIES];

   // Clearing pass.
   logic             busy_ff;
   logic [CLR_W-1:0] clr_ff;
   logic             clr_lh;
   logic             clr_lc;
   logic             clr_btb;
   logic             clr_g;

   // Second stage: local history read back, counter reads issued.
   tbp_pkg::lookup_type b_lookup_ff;
   logic [BI_W-1:0]     b_bi_ff;
   logic [LI_W-1:0]     b_li_ff;
   logic [GI_W-1:0]     b_gi_ff;
   logic [HB-1:0]       lh_rd_ff;
   logic                lh_hit_ff;
   logic [HB-1:0]       lh_fwd_ff;
   logic [HB-1:0]       hist;
   logic                lh_we;
   logic [HB-1:0]       lh_new;

   // Third stage: table data for the deciding item.
   logic [HB-1:0]          c_hist_ff;
   logic [BI_W-1:0]        c_bi_ff;
   logic [GI_W-1:0]        c_gi_ff;
   logic [1:0]             lc_rd_ff;
   logic [1:0]             gc_rd_ff;
   logic [1:0]             ch_rd_ff;
   tbp_pkg::btb_entry_type btb_rd_ff;
   logic                   lc_hit_ff;
   logic                   gc_hit_ff;
   logic                   ch_hit_ff;
   logic                   btb_hit_ff;
   logic [1:0]             lc_fwd_ff;
   logic [1:0]             gc_fwd_ff;
   logic [1:0]             ch_fwd_ff;
   tbp_pkg::btb_entry_type btb_fwd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         clr_ff  <= '0;
      end else if (busy_ff) begin
         clr_ff <= CLR_W'(clr_ff + 1'b1);
         if (clr_ff == CLR_W'(CLR_LEN - 1)) busy_ff <= 1'b0;
      end
   end

   assign busy    = busy_ff;
   assign clr_lh  = busy_ff && ({1'b0, clr_ff} < (CLR_W + 1)'(LOCAL_TABLE_ENTRIES));
   assign clr_lc  = busy_ff && ({1'b0, clr_ff} < (CLR_W + 1)'(LC_ENTRIES));
   assign clr_btb = busy_ff && ({1'b0, clr_ff} < (CLR_W + 1)'(BTB_ENTRIES));
   assign clr_g   = busy_ff && ({1'b0, clr_ff} < (CLR_W + 1)'(GLOBAL_TABLE_ENTRIES));

   // Local history, with the write from the stage ahead forwarded.
   assign hist   = lh_hit_ff ? lh_fwd_ff : lh_rd_ff;
   assign lh_we  = b_lookup_ff.valid && b_lookup_ff.train;
   assign lh_new = HB'({hist, b_lookup_ff.actual});

   always_ff @(posedge clock) begin
      if (adv) lh_rd_ff <= lh_mem[a_li];
   end

   always_ff @(posedge clock) begin
      if (clr_lh) begin
         lh_mem[clr_ff[LI_W-1:0]] <= '0;
      end else if (adv && lh_we) begin
         lh_mem[b_li_ff] <= lh_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_lookup_ff <= '0;
         lh_hit_ff   <= 1'b0;
      end else if (adv) begin
         b_lookup_ff <= a_lookup;
         lh_hit_ff   <= lh_we && (a_li == b_li_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_bi_ff   <= a_bi;
         b_li_ff   <= a_li;
         b_gi_ff   <= a_gi;
         lh_fwd_ff <= lh_new;
      end
   end

   // Counter and BTB reads.
   always_ff @(posedge clock) begin
      if (adv) begin
         lc_rd_ff  <= lc_mem[hist];
         btb_rd_ff <= btb_mem[b_bi_ff];
         gc_rd_ff  <= gc_mem[b_gi_ff];
         ch_rd_ff  <= ch_mem[b_gi_ff];
         c_hist_ff <= hist;
         c_bi_ff   <= b_bi_ff;
         c_gi_ff   <= b_gi_ff;
         lc_fwd_ff <= c_write.lc;
         gc_fwd_ff <= c_write.gc;
         ch_fwd_ff <= c_write.ch;
         btb_fwd_ff <= c_write.btb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lc_hit_ff  <= 1'b0;
         gc_hit_ff  <= 1'b0;
         ch_hit_ff  <= 1'b0;
         btb_hit_ff <= 1'b0;
      end else if (adv) begin
         lc_hit_ff  <= c_write.lc_we && (hist == c_hist_ff);
         gc_hit_ff  <= c_write.gc_we && (b_gi_ff == c_gi_ff);
         ch_hit_ff  <= c_write.ch_we && (b_gi_ff == c_gi_ff);
         btb_hit_ff <= c_write.btb_we && (b_bi_ff == c_bi_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (clr_lc) begin
         lc_mem[clr_ff[HB-1:0]] <= '0;
      end else if (adv && c_write.lc_we) begin
         lc_mem[c_hist_ff] <= c_write.lc;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_btb) begin
         btb_mem[clr_ff[BI_W-1:0]] <= '0;
      end else if (adv && c_write.btb_we) begin
         btb_mem[c_bi_ff] <= c_write.btb;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_g) begin
         gc_mem[clr_ff[GI_W-1:0]] <= '0;
      end else if (adv && c_write.gc_we) begin
         gc_mem[c_gi_ff] <= c_write.gc;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_g) begin
         ch_mem[clr_ff[GI_W-1:0]] <= '0;
      end else if (adv && c_write.ch_we) begin
         ch_mem[c_gi_ff] <= c_write.ch;
      end
   end

   assign c_read.lc  = lc_hit_ff  ? lc_fwd_ff  : lc_rd_ff;
   assign c_read.gc  = gc_hit_ff  ? gc_fwd_ff  : gc_rd_ff;
   assign c_read.ch  = ch_hit_ff  ? ch_fwd_ff  : ch_rd_ff;
   assign c_read.btb = btb_hit_ff ? btb_fwd_ff : btb_rd_ff;

endmodule

// ===== rtl/tournament_branch_predictor_core.sv =====
// Top level of the tournament branch predictor: input register, index pipeline, decision
// stage, statistics and result register. Uses tbp_pkg, tbp_mod_const, tbp_ras, tbp_tables.
//
// How the block is used.
// Items arrive on the req_ channel: a predict item (kind 0) asks for a direction and target
// for the instruction at req_pc, an update item (kind 1) trains the predictor with the
// resolved outcome. Every item gives exactly one result on the rsp_ channel, in order.
// Both channels move an item at a rising edge where valid is high and stall is low.
// Path: an accepted item passes the input register, three index stages and two table read
// stages before its result is loaded into the output register.
// Throughput: one item per cycle while rsp_stall is low; the pipeline has no internal
// stall, and back-to-back items that touch the same table entries see each other's writes
// through forwarding. Reset: all control is cleared at once, then a clearing pass zeroes the
// tables one entry per cycle, through as many entries as the deepest table has (4096 with
// the default sizes); req_stall is held high throughout.
// When the receiver stalls with a result waiting, the whole pipeline holds its state and
// req_stall rises in the same cycle; nothing is lost and work resumes when rsp_stall falls.
module tournament_branch_predictor_core #(
   parameter int BTB_ENTRIES          = 512,
   parameter int LOCAL_TABLE_ENTRIES  = 1024,
   parameter int LOCAL_HISTORY_BITS   = 10,
   parameter int GLOBAL_TABLE_ENTRIES = 4096,
   parameter int GLOBAL_HISTORY_BITS  = 12,
   parameter int RETURN_STACK_DEPTH   = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [31:0] req_pc,
   input  logic [31:0] req_raw_instruction,
   input  logic [1:0]  req_branch_class,
   input  logic [31:0] req_resolved_next_pc,
   input  logic [31:0] req_sequential_next_pc,
   input  logic [31:0] req_predicted_next_pc,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_predict_taken,
   output logic        rsp_target_valid,
   output logic [31:0] rsp_predicted_target,
   output logic [31:0] rsp_prediction_total,
   output logic [31:0] rsp_mispredict_total,
   output logic [31:0] rsp_btb_miss_total
);

   localparam int BI_W = $clog2(BTB_ENTRIES);
   localparam int LI_W = $clog2(LOCAL_TABLE_ENTRIES);
   localparam int GI_W = $clog2(GLOBAL_TABLE_ENTRIES);
   localparam int GHB  = GLOBAL_HISTORY_BITS;

   logic adv;
   logic accept;
   logic busy;

   // Input register.
   logic        s1_valid_ff;
   logic        s1_kind_ff;
   logic [31:0] s1_pc_ff;
   logic [31:0] s1_raw_ff;
   logic [1:0]  s1_class_ff;
   logic [31:0] s1_dnpc_ff;
   logic [31:0] s1_snpc_ff;
   logic [31:0] s1_ppc_ff;

   tbp_pkg::item_type s1_item;
   tbp_pkg::ras_type  ras;
   logic [GHB-1:0]    ghist_ff;
   logic [29:0]       x_pc;
   logic [29:0]       x_g;

   // Index pipeline and table stages.
   logic              m1_valid_ff;
   logic              m2_valid_ff;
   logic              a_valid_ff;
   logic              b_valid_ff;
   logic              c_valid_ff;
   tbp_pkg::item_type m1_item_ff;
   tbp_pkg::item_type m2_item_ff;
   tbp_pkg::item_type a_item_ff;
   tbp_pkg::item_type b_item_ff;
   tbp_pkg::item_type c_item_ff;

   logic [BI_W-1:0] a_bi;
   logic [LI_W-1:0] a_li;
   logic [GI_W-1:0] a_gi;

   tbp_pkg::lookup_type      a_lookup;
   tbp_pkg::table_read_type  c_read;
   tbp_pkg::table_write_type c_write;

   // Decision stage.
   logic        btb_hit;
   logic        lp;
   logic        gp;
   logic        c_train;
   logic        taken_in;
   logic        tvalid_in;
   logic [31:0] target_in;

   // Statistics and result register.
   logic [31:0] pred_total_ff;
   logic [31:0] mis_total_ff;
   logic [31:0] miss_total_ff;
   logic [31:0] pred_total_in;
   logic [31:0] mis_total_in;
   logic [31:0] miss_total_in;
   logic        rsp_valid_ff;
   logic        rsp_taken_ff;
   logic        rsp_tvalid_ff;
   logic [31:0] rsp_target_ff;

   // The whole pipeline moves together; it only holds while a result waits on a stalled port.
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = busy || !adv;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff  <= req_kind;
         s1_pc_ff    <= req_pc;
         s1_raw_ff   <= req_raw_instruction;
         s1_class_ff <= req_branch_class;
         s1_dnpc_ff  <= req_resolved_next_pc;
         s1_snpc_ff  <= req_sequential_next_pc;
         s1_ppc_ff   <= req_predicted_next_pc;
      end
   end

   // The return stack and the global history are handled here, strictly in item order, so
   // every later stage sees them as the item found them.
   tbp_ras #(
      .DEPTH (RETURN_STACK_DEPTH)
   ) u_ras (
      .clock (clock),
      .reset (reset),
      .step  (adv && s1_valid_ff && (s1_kind_ff == tbp_pkg::KIND_PREDICT)),
      .pc    (s1_pc_ff),
      .raw   (s1_raw_ff),
      .ret   (ras)
   );

   always_comb begin
      s1_item.predict    = (s1_kind_ff == tbp_pkg::KIND_PREDICT);
      s1_item.train      = (s1_kind_ff == tbp_pkg::KIND_UPDATE) &&
                           (s1_class_ff != tbp_pkg::CLASS_OTHER);
      s1_item.actual     = (s1_dnpc_ff != s1_snpc_ff);
      s1_item.mispredict = (s1_dnpc_ff != s1_ppc_ff);
      s1_item.tag        = s1_pc_ff[31:tbp_pkg::TAG_SHIFT];
      s1_item.new_target = s1_dnpc_ff;
      s1_item.ret_pop    = ras.pop;
      s1_item.ret_target = ras.target;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ghist_ff <= '0;
      end else if (adv && s1_valid_ff && s1_item.train) begin
         ghist_ff <= GHB'({ghist_ff, s1_item.actual});
      end
   end

   assign x_pc = s1_pc_ff[31:2];
   assign x_g  = 30'(ghist_ff) ^ x_pc;

   tbp_mod_const #(.WIDTH(30), .DIVISOR(BTB_ENTRIES)) u_mod_btb (
      .clock     (clock),
      .enable    (adv),
      .value     (x_pc),
      .remainder (a_bi)
   );

   tbp_mod_const #(.WIDTH(30), .DIVISOR(LOCAL_TABLE_ENTRIES)) u_mod_local (
      .clock     (clock),
      .enable    (adv),
      .value     (x_pc),
      .remainder (a_li)
   );

   tbp_mod_const #(.WIDTH(30), .DIVISOR(GLOBAL_TABLE_ENTRIES)) u_mod_global (
      .clock     (clock),
      .enable    (adv),
      .value     (x_g),
      .remainder (a_gi)
   );

   // Payload runs alongside the index units and then the table read stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
         a_valid_ff  <= 1'b0;
         b_valid_ff  <= 1'b0;
         c_valid_ff  <= 1'b0;
      end else if (adv) begin
         m1_valid_ff <= s1_valid_ff;
         m2_valid_ff <= m1_valid_ff;
         a_valid_ff  <= m2_valid_ff;
         b_valid_ff  <= a_valid_ff;
         c_valid_ff  <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_item_ff <= s1_item;
         m2_item_ff <= m1_item_ff;
         a_item_ff  <= m2_item_ff;
         b_item_ff  <= a_item_ff;
         c_item_ff  <= b_item_ff;
      end
   end

   assign a_lookup.valid  = a_valid_ff;
   assign a_lookup.train  = a_item_ff.train;
   assign a_lookup.actual = a_item_ff.actual;

   tbp_tables #(
      .BTB_ENTRIES          (BTB_ENTRIES),
      .LOCAL_TABLE_ENTRIES  (LOCAL_TABLE_ENTRIES),
      .LOCAL_HISTORY_BITS   (LOCAL_HISTORY_BITS),
      .GLOBAL_TABLE_ENTRIES (GLOBAL_TABLE_ENTRIES)
   ) u_tables (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .a_lookup (a_lookup),
      .a_bi     (a_bi),
      .a_li     (a_li),
      .a_gi     (a_gi),
      .c_read   (c_read),
      .c_write  (c_write),
      .busy     (busy)
   );

   // Decision stage: a popped return wins outright; otherwise the BTB supplies the target and
   // the chooser picks between the local and gshare directions.
   assign btb_hit = c_read.btb.valid && (c_read.btb.tag == c_item_ff.tag);
   assign lp      = c_read.lc[1];
   assign gp      = c_read.gc[1];
   assign c_train = c_valid_ff && c_item_ff.train;

   always_comb begin
      taken_in  = 1'b0;
      tvalid_in = 1'b0;
      target_in = '0;
      if (c_item_ff.predict) begin
         if (c_item_ff.ret_pop) begin
            taken_in  = 1'b1;
            tvalid_in = 1'b1;
            target_in = c_item_ff.ret_target;
         end else begin
            tvalid_in = btb_hit;
            target_in = btb_hit ? c_read.btb.target : '0;
            taken_in  = c_read.ch[1] ? gp : lp;
         end
      end
   end

   // Training writes. The chooser only moves when the two predictors disagreed.
   always_comb begin
      c_write.lc_we         = c_train;
      c_write.lc            = tbp_pkg::ctr_move(c_read.lc, c_item_ff.actual);
      c_write.gc_we         = c_train;
      c_write.gc            = tbp_pkg::ctr_move(c_read.gc, c_item_ff.actual);
      c_write.ch_we         = c_train && (lp != gp);
      c_write.ch            = tbp_pkg::ctr_move(c_read.ch, c_item_ff.actual == gp);
      c_write.btb_we        = c_train && c_item_ff.actual;
      c_write.btb.valid     = 1'b1;
      c_write.btb.tag       = c_item_ff.tag;
      c_write.btb.target    = c_item_ff.new_target;
   end

   always_comb begin
      pred_total_in = pred_total_ff;
      mis_total_in  = mis_total_ff;
      miss_total_in = miss_total_ff;
      if (c_train) begin
         pred_total_in = tbp_pkg::sat_inc(pred_total_ff);
         if (c_item_ff.mispredict) mis_total_in = tbp_pkg::sat_inc(mis_total_ff);
         if (c_item_ff.actual && !btb_hit) miss_total_in = tbp_pkg::sat_inc(miss_total_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pred_total_ff <= '0;
         mis_total_ff  <= '0;
         miss_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else if (adv) begin
         pred_total_ff <= pred_total_in;
         mis_total_ff  <= mis_total_in;
         miss_total_ff <= miss_total_in;
         rsp_valid_ff  <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && c_valid_ff) begin
         rsp_taken_ff  <= taken_in;
         rsp_tvalid_ff <= tvalid_in;
         rsp_target_ff <= target_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_predict_taken    = rsp_taken_ff;
   assign rsp_target_valid     = rsp_tvalid_ff;
   assign rsp_predicted_target = rsp_target_ff;
   assign rsp_prediction_total = pred_total_ff;
   assign rsp_mispredict_total = mis_total_ff;
   assign rsp_btb_miss_total   = miss_total_ff;

endmodule
